/* rtl/psmr_pkg.sv */
// Shared types and constants for the per-sender message reassembler.
// Used by psmr_store and per_sender_message_reassembler_core; no dependencies.

package psmr_pkg;

   localparam int TYPE_W     = 2;
   localparam int SENDER_W   = 4;
   localparam int ID_W       = 16;
   localparam int MSIZE_W    = 8;
   localparam int BYTE_W     = 8;
   localparam int PAYLOAD_W  = 56;
   localparam int OUT_SIZE_W = 6;

   typedef logic [TYPE_W-1:0]     frag_kind_type;
   typedef logic [SENDER_W-1:0]   sender_type;
   typedef logic [ID_W-1:0]       id_type;
   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [PAYLOAD_W-1:0]  payload_type;
   typedef logic [OUT_SIZE_W-1:0] out_size_type;

   localparam frag_kind_type FRAG_HEADER = 2'd0;
   localparam frag_kind_type FRAG_DATA   = 2'd1;

endpackage

/* rtl/per_sender_message_reassembler_core.sv */
// Top level of the per-sender message reassembler.
// Depends on psmr_pkg and psmr_store.
//
// Usage: a fragment transaction is taken when start is high and busy is low.
// A header fragment (req_type 0) opens a message for its sender if its size
// is at most MAX_MSG_BYTES; busy stays low, so headers can follow back to
// back. A data fragment (req_type 1) for an open message copies up to
// FRAG_BYTES payload bytes into the byte buffer, one byte per cycle through
// its single write port, with busy high while bytes are taken. If that
// completes the message, the buffer is read back one byte per cycle through
// its read port: results appear on the rsp_ ports from its registered read
// data, one per cycle with rsp_strobe high, rsp_last marking the final one.
// An empty message gives one result with rsp_byte_valid low in the cycle
// after acceptance. Fragments of other kinds, for senders at or above
// NUM_CONTEXTS, or data with no open message, are taken without raising busy
// and give no result. Reset clears every sender context; the byte buffer
// needs no clearing. The receiver cannot stall: every result is taken in the
// cycle it is shown.

module per_sender_message_reassembler_core #(
   parameter int NUM_CONTEXTS  = 5,
   parameter int MAX_MSG_BYTES = 35,
   parameter int FRAG_BYTES    = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  psmr_pkg::frag_kind_type  req_type,
   input  psmr_pkg::sender_type     req_sender,
   input  psmr_pkg::id_type         req_dest,
   input  psmr_pkg::id_type         req_msg_id,
   input  logic [psmr_pkg::MSIZE_W-1:0] req_msg_size,
   input  psmr_pkg::payload_type    req_payload,
   output logic                     rsp_strobe,
   output psmr_pkg::sender_type     rsp_out_sender,
   output psmr_pkg::id_type         rsp_out_dest,
   output psmr_pkg::id_type         rsp_out_id,
   output psmr_pkg::out_size_type   rsp_out_size,
   output psmr_pkg::out_size_type   rsp_byte_index,
   output psmr_pkg::byte_type       rsp_byte_value,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last
);
   import psmr_pkg::*;

   localparam int DEPTH  = NUM_CONTEXTS * MAX_MSG_BYTES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int CNT_W  = $clog2(MAX_MSG_BYTES + 1);
   localparam int TK_W   = $clog2(FRAG_BYTES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_COPY = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Per-sender context registers.
   logic             ctx_active_ff [NUM_CONTEXTS];
   logic [CNT_W-1:0] ctx_rcv_ff    [NUM_CONTEXTS];
   id_type           ctx_id_ff     [NUM_CONTEXTS];
   logic [CNT_W-1:0] ctx_size_ff   [NUM_CONTEXTS];

   logic             ctx_we;
   logic             ctx_active_in;
   logic [CNT_W-1:0] ctx_rcv_in;
   id_type           ctx_id_in;
   logic [CNT_W-1:0] ctx_size_in;

   // Job registers for the fragment being copied or emitted.
   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [TK_W-1:0]   left_ff, left_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              done_ff, done_in;
   payload_type       pay_ff, pay_in;
   sender_type        sender_ff, sender_in;
   id_type            dest_ff, dest_in;
   id_type            id_ff, id_in;
   logic [CNT_W-1:0]  size_ff, size_in;

   // Result pending on the buffer's read data.
   logic              pend_ff, pend_in;
   logic              pend_byte_ff, pend_byte_in;
   logic              pend_last_ff, pend_last_in;
   logic [CNT_W-1:0]  pend_idx_ff, pend_idx_in;

   logic              accept;
   logic              in_range;
   logic [CTX_W-1:0]  ci;
   logic [7:0]        left8, take8;
   logic [CNT_W-1:0]  cur_size, cur_rcv;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   byte_type          rd_data;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_sender} < 5'(NUM_CONTEXTS));
   assign ci       = CTX_W'(req_sender);
   assign cur_size = ctx_size_ff[ci];
   assign cur_rcv  = ctx_rcv_ff[ci];
   assign left8    = 8'(cur_size) - 8'(cur_rcv);
   assign take8    = (left8 > 8'(FRAG_BYTES)) ? 8'(FRAG_BYTES) : left8;

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      rd_idx_in     = rd_idx_ff;
      done_in       = done_ff;
      pay_in        = pay_ff;
      sender_in     = sender_ff;
      dest_in       = dest_ff;
      id_in         = id_ff;
      size_in       = size_ff;
      pend_in       = 1'b0;
      pend_byte_in  = pend_byte_ff;
      pend_last_in  = pend_last_ff;
      pend_idx_in   = pend_idx_ff;
      ctx_we        = 1'b0;
      ctx_active_in = 1'b0;
      ctx_rcv_in    = '0;
      ctx_id_in     = ctx_id_ff[ci];
      ctx_size_in   = cur_size;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      wr_addr       = base_ff + ADDR_W'(pos_ff);
      rd_addr       = base_ff + ADDR_W'(rd_idx_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               if (req_type == FRAG_HEADER) begin
                  ctx_we        = 1'b1;
                  ctx_id_in     = req_msg_id;
                  ctx_size_in   = CNT_W'(req_msg_size);
                  ctx_rcv_in    = '0;
                  ctx_active_in = (req_msg_size <= 8'(MAX_MSG_BYTES));
               end else if (req_type == FRAG_DATA && ctx_active_ff[ci]) begin
                  ctx_we    = 1'b1;
                  base_in   = ADDR_W'(ci * MAX_MSG_BYTES);
                  pos_in    = cur_rcv;
                  left_in   = TK_W'(take8);
                  rd_idx_in = '0;
                  done_in   = (take8 == left8);
                  pay_in    = req_payload;
                  sender_in = req_sender;
                  dest_in   = req_dest;
                  id_in     = ctx_id_ff[ci];
                  size_in   = cur_size;
                  // A completed message closes its context at once.
                  if (take8 == left8) begin
                     ctx_active_in = 1'b0;
                     ctx_rcv_in    = '0;
                  end else begin
                     ctx_active_in = 1'b1;
                     ctx_rcv_in    = cur_rcv + CNT_W'(take8);
                  end
                  if (take8 == 8'd0) begin
                     // Empty message: one result that carries no byte.
                     pend_in      = 1'b1;
                     pend_byte_in = 1'b0;
                     pend_last_in = 1'b1;
                     pend_idx_in  = '0;
                  end else begin
                     state_in = ST_COPY;
                  end
               end
            end
         end
         ST_COPY: begin
            wr_en   = 1'b1;
            pay_in  = pay_ff >> BYTE_W;
            pos_in  = pos_ff + 1'b1;
            left_in = left_ff - 1'b1;
            if (left_ff == TK_W'(1)) begin
               state_in = done_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            pend_in      = 1'b1;
            pend_byte_in = 1'b1;
            pend_idx_in  = rd_idx_ff;
            pend_last_in = (rd_idx_ff + 1'b1 == size_ff);
            rd_idx_in    = rd_idx_ff + 1'b1;
            if (rd_idx_ff + 1'b1 == size_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         for (int k = 0; k < NUM_CONTEXTS; k++) begin
            ctx_active_ff[k] <= 1'b0;
            ctx_rcv_ff[k]    <= '0;
            ctx_id_ff[k]     <= '0;
            ctx_size_ff[k]   <= '0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         if (ctx_we) begin
            ctx_active_ff[ci] <= ctx_active_in;
            ctx_rcv_ff[ci]    <= ctx_rcv_in;
            ctx_id_ff[ci]     <= ctx_id_in;
            ctx_size_ff[ci]   <= ctx_size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      pos_ff       <= pos_in;
      left_ff      <= left_in;
      rd_idx_ff    <= rd_idx_in;
      done_ff      <= done_in;
      pay_ff       <= pay_in;
      sender_ff    <= sender_in;
      dest_ff      <= dest_in;
      id_ff        <= id_in;
      size_ff      <= size_in;
      pend_byte_ff <= pend_byte_in;
      pend_last_ff <= pend_last_in;
      pend_idx_ff  <= pend_idx_in;
   end

   psmr_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pay_ff[BYTE_W-1:0]),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe     = pend_ff;
   assign rsp_out_sender = sender_ff;
   assign rsp_out_dest   = dest_ff;
   assign rsp_out_id     = id_ff;
   assign rsp_out_size   = OUT_SIZE_W'(size_ff);
   assign rsp_byte_index = OUT_SIZE_W'(pend_idx_ff);
   assign rsp_byte_value = pend_byte_ff ? rd_data : '0;
   assign rsp_byte_valid = pend_byte_ff;
   assign rsp_last       = pend_last_ff;

endmodule

/* rtl/psmr_store.sv */
// Message byte buffer: one write port, one read port, registered read data.
// Depends on psmr_pkg for the byte type.

module psmr_store #(
   parameter int DEPTH  = 175,
   parameter int ADDR_W = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  psmr_pkg::byte_type   wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output psmr_pkg::byte_type   rd_data
);
   import psmr_pkg::*;

   byte_type mem_ff [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
